@@ src/ssc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg: shared constants of the sphere contact pipeline
// Stage counts and guard widths that the top level and the divider agree on.
// ----------------------------------------------------------------------------
package ssc_pkg;

    // Quotient bits kept beyond the coordinate width; larger quotients clamp.
    localparam int unsigned DIV_GUARD_BITS = 2;

    // Divider stages ahead of the first quotient bit: product, rounding add,
    // range check.
    localparam int unsigned PRE_DIV_STAGES = 3;

endpackage

`default_nettype wire

@@ src/sphere_sphere_contact.sv @@
// Throughput: one item per cycle unless stalled; the root and the three
// dividers are fully pipelined, one result bit per stage, and the whole pipe
// advances together. A stalled result freezes every stage; input stall
// follows output stall. Reset (synchronous, active low) clears all valid
// bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_sphere_contact: sphere pair hit test and contact point
// Tests |A-B| < rA + rB exactly and returns B + (A-B)*rB/d on a hit.
// ----------------------------------------------------------------------------
module sphere_sphere_contact #(
    parameter int unsigned COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_BITS-1:0]  i_a_x,
    input  logic signed [COORD_BITS-1:0]  i_a_y,
    input  logic signed [COORD_BITS-1:0]  i_a_z,
    input  logic        [COORD_BITS-2:0]  i_a_radius,
    input  logic signed [COORD_BITS-1:0]  i_b_x,
    input  logic signed [COORD_BITS-1:0]  i_b_y,
    input  logic signed [COORD_BITS-1:0]  i_b_z,
    input  logic        [COORD_BITS-2:0]  i_b_radius,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic signed [COORD_BITS-1:0]  o_contact_x,
    output logic signed [COORD_BITS-1:0]  o_contact_y,
    output logic signed [COORD_BITS-1:0]  o_contact_z
);
    localparam int unsigned W         = COORD_BITS;
    localparam int unsigned Q         = W + ssc_pkg::DIV_GUARD_BITS;
    localparam int unsigned SQRT_LAT  = W + 1;
    localparam int unsigned DIV_LAT   = ssc_pkg::PRE_DIV_STAGES + Q;
    localparam int unsigned SIDE_LAT  = SQRT_LAT + DIV_LAT;
    localparam int unsigned DEPTH     = 4 + SIDE_LAT + 2;
    localparam int unsigned SIDE_W    = 3*W + 5;
    localparam int unsigned MR_W      = 4*W - 1;
    localparam logic [Q-1:0] Q_LIM    = {1'b1, {(Q-1){1'b0}}};

    // Whole pipe moves unless a finished result is held by the receiver.
    logic en;
    assign o_stall = o_valid && i_stall;
    assign en      = !o_stall;

    logic r_vld [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) r_vld[k] <= r_vld[k-1];
        end
    end
    assign o_valid = r_vld[DEPTH-1];

    // Stage 1: per-axis difference A - B as sign and magnitude; radius sum.
    logic [W-1:0] in_a [3];
    logic [W-1:0] in_b [3];
    assign in_a[0] = i_a_x;
    assign in_a[1] = i_a_y;
    assign in_a[2] = i_a_z;
    assign in_b[0] = i_b_x;
    assign in_b[1] = i_b_y;
    assign in_b[2] = i_b_z;

    logic [W-1:0] n1_mag [3];
    logic         n1_neg [3];
    always_comb begin
        logic [W:0] diff;
        logic [W:0] mag;
        for (int i = 0; i < 3; i++) begin
            diff      = {in_a[i][W-1], in_a[i]} - {in_b[i][W-1], in_b[i]};
            mag       = diff[W] ? (~diff + 1'b1) : diff;
            n1_mag[i] = mag[W-1:0];
            n1_neg[i] = diff[W];
        end
    end

    logic [W-1:0]   r1_mag [3];
    logic           r1_neg [3];
    logic [W-1:0]   r1_b   [3];
    logic [W-2:0]   r1_rb;
    logic [W-1:0]   r1_s;

    logic [2*W-1:0] r2_sq  [3];
    logic [2*W-1:0] r2_ss;
    logic [W-1:0]   r2_mag [3];
    logic           r2_neg [3];
    logic [W-1:0]   r2_b   [3];
    logic [W-2:0]   r2_rb;

    logic [2*W+1:0] r3_d2;
    logic [2*W-1:0] r3_ss;
    logic [W-1:0]   r3_mag [3];
    logic           r3_neg [3];
    logic [W-1:0]   r3_b   [3];
    logic [W-2:0]   r3_rb;

    logic           r4_hit;
    logic           r4_zero;
    logic [2*W-1:0] r4_rad;
    logic [W-1:0]   r4_mag [3];
    logic           r4_neg [3];
    logic [W-1:0]   r4_b   [3];
    logic [W-2:0]   r4_rb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Stage 1
            for (int i = 0; i < 3; i++) begin
                r1_mag[i] <= n1_mag[i];
                r1_neg[i] <= n1_neg[i];
                r1_b[i]   <= in_b[i];
            end
            r1_rb <= i_b_radius;
            r1_s  <= {1'b0, i_a_radius} + {1'b0, i_b_radius};
            // Stage 2: squares of the differences and of the radius sum.
            for (int i = 0; i < 3; i++) begin
                r2_sq[i]  <= r1_mag[i] * r1_mag[i];
                r2_mag[i] <= r1_mag[i];
                r2_neg[i] <= r1_neg[i];
                r2_b[i]   <= r1_b[i];
            end
            r2_ss <= r1_s * r1_s;
            r2_rb <= r1_rb;
            // Stage 3: squared center distance, exact.
            r3_d2 <= {2'b00, r2_sq[0]} + {2'b00, r2_sq[1]} + {2'b00, r2_sq[2]};
            r3_ss <= r2_ss;
            for (int i = 0; i < 3; i++) begin
                r3_mag[i] <= r2_mag[i];
                r3_neg[i] <= r2_neg[i];
                r3_b[i]   <= r2_b[i];
            end
            r3_rb <= r2_rb;
            // Stage 4: hit test without a root; coincident centers flag.
            r4_hit  <= (r3_d2 < {2'b00, r3_ss});
            r4_zero <= (r3_d2 == '0);
            r4_rad  <= r3_d2[2*W-1:0];
            for (int i = 0; i < 3; i++) begin
                r4_mag[i] <= r3_mag[i];
                r4_neg[i] <= r3_neg[i];
                r4_b[i]   <= r3_b[i];
            end
            r4_rb <= r3_rb;
        end
    end

    // Rounded center distance. On a hit the radicand is below (rA+rB)^2,
    // so the low 2*COORD_BITS bits carry it whole.
    logic [W-1:0] root_d;
    ssc_isqrt #(
        .COORD_BITS (W)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r4_rad),
        .o_root (root_d)
    );

    // Hold magnitudes and rB alongside the root.
    logic [MR_W-1:0] mr_in;
    logic [MR_W-1:0] r_mr [SQRT_LAT];
    assign mr_in = {r4_rb, r4_mag[2], r4_mag[1], r4_mag[0]};

    // Hold hit, coincidence, signs and B alongside root and division.
    logic [SIDE_W-1:0] side_in;
    logic [SIDE_W-1:0] r_side [SIDE_LAT];
    assign side_in = {r4_b[2], r4_b[1], r4_b[0],
                      r4_neg[2], r4_neg[1], r4_neg[0], r4_zero, r4_hit};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mr[0] <= mr_in;
            for (int k = 1; k < SQRT_LAT; k++) r_mr[k] <= r_mr[k-1];
            r_side[0] <= side_in;
            for (int k = 1; k < SIDE_LAT; k++) r_side[k] <= r_side[k-1];
        end
    end

    logic [W-2:0] dv_rb;
    assign dv_rb = r_mr[SQRT_LAT-1][MR_W-1 -: (W-1)];

    // Offset magnitude per axis: |A-B| * rB / d, rounded.
    logic [Q-1:0] quo [3];
    logic         ovf [3];
    for (genvar g = 0; g < 3; g++) begin : g_axis
        ssc_div #(
            .COORD_BITS (W)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_mag (r_mr[SQRT_LAT-1][g*W +: W]),
            .i_rb  (dv_rb),
            .i_d   (root_d),
            .o_quo (quo[g]),
            .o_ovf (ovf[g])
        );
    end

    logic [SIDE_W-1:0] side_out;
    assign side_out = r_side[SIDE_LAT-1];

    // Stage F1: clamp the quotient, apply the sign, add to B.
    logic [W+2:0] n5_sum [3];
    always_comb begin
        logic [Q-1:0] qc;
        logic [W+2:0] qe;
        logic [W+2:0] off;
        logic [W-1:0] bb;
        for (int i = 0; i < 3; i++) begin
            qc        = (ovf[i] || (quo[i] > Q_LIM)) ? Q_LIM : quo[i];
            qe        = (W+3)'(qc);
            off       = side_out[2+i] ? (~qe + 1'b1) : qe;
            bb        = side_out[5+i*W +: W];
            n5_sum[i] = {{3{bb[W-1]}}, bb} + off;
        end
    end

    logic [W+2:0] r5_sum [3];
    logic [W-1:0] r5_b   [3];
    logic         r5_hit;
    logic         r5_zero;

    // Stage F2: saturate; coincident centers give B (equal to A); miss gives 0.
    logic [W-1:0] n_res [3];
    always_comb begin
        logic [W+2:0] s;
        for (int i = 0; i < 3; i++) begin
            s = r5_sum[i];
            if (!r5_hit) begin
                n_res[i] = '0;
            end else if (r5_zero) begin
                n_res[i] = r5_b[i];
            end else if (!s[W+2] && (|s[W+1:W-1])) begin
                n_res[i] = {1'b0, {(W-1){1'b1}}};
            end else if (s[W+2] && !(&s[W+1:W-1])) begin
                n_res[i] = {1'b1, {(W-1){1'b0}}};
            end else begin
                n_res[i] = s[W-1:0];
            end
        end
    end

    logic         r_hit;
    logic [W-1:0] r_res [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r5_sum[i] <= n5_sum[i];
                r5_b[i]   <= side_out[5+i*W +: W];
                r_res[i]  <= n_res[i];
            end
            r5_hit  <= side_out[0];
            r5_zero <= side_out[1];
            r_hit   <= r5_hit;
        end
    end

    assign o_hit       = r_hit;
    assign o_contact_x = r_res[0];
    assign o_contact_y = r_res[1];
    assign o_contact_z = r_res[2];

endmodule

`default_nettype wire

@@ src/ssc_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_isqrt: pipelined integer square root, rounded to nearest
// One result bit per stage, then one rounding stage.
// ----------------------------------------------------------------------------
module ssc_isqrt #(
    parameter int unsigned COORD_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [2*COORD_BITS-1:0]   i_rad,
    output logic [COORD_BITS-1:0]     o_root
);
    localparam int unsigned W = COORD_BITS;

    logic [W:0]     r_rem  [W];
    logic [W-1:0]   r_root [W];
    logic [2*W-1:0] r_rest [W];
    logic [W:0]     n_rem  [W];
    logic [W-1:0]   n_root [W];
    logic [2*W-1:0] n_rest [W];
    logic [W-1:0]   r_d;

    // One digit step per stage: bring down two radicand bits, try root*4+1.
    always_comb begin
        logic [W:0]     rem_p;
        logic [W-1:0]   root_p;
        logic [2*W-1:0] rest_p;
        logic [W+1:0]   t;
        logic [W+1:0]   trial;
        logic [W+1:0]   sub;
        logic           ge;
        for (int k = 0; k < W; k++) begin
            if (k == 0) begin
                rem_p  = '0;
                root_p = '0;
                rest_p = i_rad;
            end else begin
                rem_p  = r_rem[k-1];
                root_p = r_root[k-1];
                rest_p = r_rest[k-1];
            end
            t         = {rem_p[W-1:0], rest_p[2*W-1 -: 2]};
            trial     = {root_p, 2'b01};
            ge        = (t >= trial);
            sub       = t - trial;
            n_rem[k]  = ge ? sub[W:0] : t[W:0];
            n_root[k] = {root_p[W-2:0], ge};
            n_rest[k] = {rest_p[2*W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rest[k] <= n_rest[k];
            end
            // Round up when the remainder exceeds the root.
            r_d <= (r_rem[W-1] > {1'b0, r_root[W-1]}) ? r_root[W-1] + 1'b1
                                                       : r_root[W-1];
        end
    end

    assign o_root = r_d;

endmodule

`default_nettype wire

@@ src/ssc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_div: pipelined rounded scale-and-divide, (mag * rb + d/2) / d
// Product, rounding add and range check, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module ssc_div #(
    parameter int unsigned COORD_BITS = 24
) (
    input  logic                                             i_clk,
    input  logic                                             i_en,
    input  logic [COORD_BITS-1:0]                            i_mag,
    input  logic [COORD_BITS-2:0]                            i_rb,
    input  logic [COORD_BITS-1:0]                            i_d,
    output logic [COORD_BITS+ssc_pkg::DIV_GUARD_BITS-1:0]    o_quo,
    output logic                                             o_ovf
);
    localparam int unsigned W = COORD_BITS;
    localparam int unsigned Q = W + ssc_pkg::DIV_GUARD_BITS;

    logic [2*W-2:0] r_prod;
    logic [W-1:0]   r_d0;
    logic [2*W-1:0] r_num;
    logic [W-1:0]   r_d1;
    logic [W-1:0]   r_rm2;
    logic [Q-1:0]   r_low2;
    logic [W-1:0]   r_d2;
    logic           r_ovf2;

    logic [W-1:0]   r_qrem [Q];
    logic [Q-1:0]   r_qlow [Q];
    logic [W-1:0]   r_qd   [Q];
    logic           r_qovf [Q];
    logic [W-1:0]   n_qrem [Q];
    logic [Q-1:0]   n_qlow [Q];

    logic [W-Q+W-1:0] num_hi;
    assign num_hi = r_num[2*W-1:Q];

    // Restoring division, one quotient bit per stage.
    always_comb begin
        logic [W-1:0] rem_p;
        logic [Q-1:0] low_p;
        logic [W-1:0] d_p;
        logic [W:0]   t;
        logic [W:0]   sub;
        logic         ge;
        for (int j = 0; j < Q; j++) begin
            if (j == 0) begin
                rem_p = r_rm2;
                low_p = r_low2;
                d_p   = r_d2;
            end else begin
                rem_p = r_qrem[j-1];
                low_p = r_qlow[j-1];
                d_p   = r_qd[j-1];
            end
            t         = {rem_p, low_p[Q-1]};
            ge        = (t >= {1'b0, d_p});
            sub       = t - {1'b0, d_p};
            n_qrem[j] = ge ? sub[W-1:0] : t[W-1:0];
            n_qlow[j] = {low_p[Q-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_mag * i_rb;
            r_d0   <= i_d;
            r_num  <= {1'b0, r_prod} + (2*W)'(r_d0 >> 1);
            r_d1   <= r_d0;
            // Quotient too wide for the kept bits: flag it and clamp later.
            r_ovf2 <= (W'(num_hi) >= r_d1);
            r_rm2  <= W'(num_hi);
            r_low2 <= r_num[Q-1:0];
            r_d2   <= r_d1;
            for (int j = 0; j < Q; j++) begin
                r_qrem[j] <= n_qrem[j];
                r_qlow[j] <= n_qlow[j];
                if (j == 0) begin
                    r_qd[j]   <= r_d2;
                    r_qovf[j] <= r_ovf2;
                end else begin
                    r_qd[j]   <= r_qd[j-1];
                    r_qovf[j] <= r_qovf[j-1];
                end
            end
        end
    end

    assign o_quo = r_qlow[Q-1];
    assign o_ovf = r_qovf[Q-1];

endmodule

`default_nettype wire
